@@ hdl/tdau_pkg.sv @@
// Package for the time-of-day arithmetic unit: operation and order codes,
// time constants, stage payload types and the small floored normalizer.
// No dependencies.
package tdau_pkg;

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_SUB     = 2'd1;
   localparam logic [1:0] OP_COMPARE = 2'd2;
   localparam logic [1:0] OP_DELTA   = 2'd3;

   localparam logic [1:0] ORD_EQUAL   = 2'd0;
   localparam logic [1:0] ORD_EARLIER = 2'd1;
   localparam logic [1:0] ORD_LATER   = 2'd2;

   localparam logic signed [31:0] NS_PER_SEC   = 32'sd1000000000;
   localparam logic signed [31:0] NS_PER_2SEC  = 32'sd2000000000;
   localparam logic signed [8:0]  MINUTE_SECS  = 9'sd60;
   localparam logic signed [8:0]  MIN_PER_HOUR = 9'sd60;
   localparam logic signed [8:0]  HOUR_PER_DAY = 9'sd24;
   localparam logic signed [27:0] SEC_PER_DAY  = 28'sd86400;
   localparam logic signed [27:0] SEC_PER_HOUR = 28'sd3600;
   localparam logic signed [27:0] MINUTE_SECS_W = 28'sd60;
   localparam logic signed [27:0] DELTA_MAX    = 28'sd33554431;
   localparam logic signed [27:0] DELTA_MIN    = -28'sd33554432;

   typedef struct packed {
      logic [8:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [29:0] nsec;
   } time_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [1:0]         order;
      logic signed [31:0] ns_sum;
      logic signed [8:0]  sec;
      logic signed [8:0]  min;
      logic signed [8:0]  hour;
      logic signed [10:0] day;
   } s1_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [1:0]         order;
      logic signed [2:0]  ns_q;
      logic [29:0]        ns_r;
      logic signed [8:0]  sec;
      logic signed [8:0]  min;
      logic signed [8:0]  hour;
      logic signed [10:0] day;
      logic signed [27:0] p_day;
      logic signed [27:0] p_hour;
      logic signed [27:0] p_min;
   } s2_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [1:0]         order;
      logic [29:0]        ns_r;
      logic [5:0]         sec_r;
      logic [5:0]         min_r;
      logic signed [8:0]  hour;
      logic signed [10:0] day;
      logic signed [27:0] tot;
   } s3_type;

   typedef struct packed {
      logic [29:0]        delta_nsec;
      logic signed [25:0] delta_sec;
      logic [1:0]         order;
      logic [29:0]        res_nsec;
      logic [5:0]         res_second;
      logic [5:0]         res_minute;
      logic [4:0]         res_hour;
      logic signed [10:0] res_day;
   } rsp_type;

   typedef struct packed {
      logic signed [2:0] q;
      logic [5:0]        r;
   } small_type;

   // floored divide/modulo for -2m <= x < 3m
   function automatic small_type norm_small(input logic signed [8:0] x,
                                            input logic signed [8:0] m);
      small_type         res;
      logic signed [8:0] m2;
      logic signed [8:0] r;
      m2 = m + m;
      if (x < -m) begin
         res.q = -3'sd2;
         r     = x + m2;
      end else if (x < 9'sd0) begin
         res.q = -3'sd1;
         r     = x + m;
      end else if (x < m) begin
         res.q = 3'sd0;
         r     = x;
      end else if (x < m2) begin
         res.q = 3'sd1;
         r     = x - m;
      end else begin
         res.q = 3'sd2;
         r     = x - m2;
      end
      res.r = r[5:0];
      return res;
   endfunction

endpackage

@@ hdl/tdau_prep.sv @@
// First stage: signed field sums or differences and the time compare on
// day, hour, minute and second, not nsec. Depends on tdau_pkg.
module tdau_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          in_op,
   input  tdau_pkg::time_type  in_a,
   input  tdau_pkg::time_type  in_b,
   output logic                out_valid,
   input  logic                out_ready,
   output tdau_pkg::s1_type    out_data
);

   tdau_pkg::s1_type st_ff, st_in;
   logic             v_ff;
   logic             add;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      add       = (in_op == tdau_pkg::OP_ADD);
      st_in.op  = in_op;
      if (add) begin
         st_in.ns_sum = $signed({2'b00, in_a.nsec}) + $signed({2'b00, in_b.nsec});
         st_in.sec    = $signed({3'b000, in_a.second}) + $signed({3'b000, in_b.second});
         st_in.min    = $signed({3'b000, in_a.minute}) + $signed({3'b000, in_b.minute});
         st_in.hour   = $signed({4'b0000, in_a.hour}) + $signed({4'b0000, in_b.hour});
         st_in.day    = $signed({2'b00, in_a.day}) + $signed({2'b00, in_b.day});
      end else begin
         st_in.ns_sum = $signed({2'b00, in_a.nsec}) - $signed({2'b00, in_b.nsec});
         st_in.sec    = $signed({3'b000, in_a.second}) - $signed({3'b000, in_b.second});
         st_in.min    = $signed({3'b000, in_a.minute}) - $signed({3'b000, in_b.minute});
         st_in.hour   = $signed({4'b0000, in_a.hour}) - $signed({4'b0000, in_b.hour});
         st_in.day    = $signed({2'b00, in_a.day}) - $signed({2'b00, in_b.day});
      end
      if (in_a.day != in_b.day) begin
         st_in.order = (in_a.day < in_b.day) ? tdau_pkg::ORD_EARLIER : tdau_pkg::ORD_LATER;
      end else if (in_a.hour != in_b.hour) begin
         st_in.order = (in_a.hour < in_b.hour) ? tdau_pkg::ORD_EARLIER : tdau_pkg::ORD_LATER;
      end else if (in_a.minute != in_b.minute) begin
         st_in.order = (in_a.minute < in_b.minute) ? tdau_pkg::ORD_EARLIER
                                                   : tdau_pkg::ORD_LATER;
      end else if (in_a.second != in_b.second) begin
         st_in.order = (in_a.second < in_b.second) ? tdau_pkg::ORD_EARLIER
                                                   : tdau_pkg::ORD_LATER;
      end else begin
         st_in.order = tdau_pkg::ORD_EQUAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = st_ff;

endmodule

@@ hdl/tdau_carry.sv @@
// Stages two and three: nanosecond carry, delta partial products,
// second and minute carry and the delta sum. Depends on tdau_pkg.
module tdau_carry (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tdau_pkg::s1_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tdau_pkg::s3_type  out_data
);

   tdau_pkg::s2_type   st2_ff, st2_in;
   tdau_pkg::s3_type   st3_ff, st3_in;
   logic               v2_ff, v3_ff;
   logic               rdy2, rdy3;
   logic signed [31:0] ns_off;
   logic signed [31:0] ns_r;
   logic [27:0]        day_x, hour_x, min_x;
   tdau_pkg::small_type sec_n, min_n;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = rdy2;

   // stage 2
   always_comb begin
      if (in_data.ns_sum < -tdau_pkg::NS_PER_SEC) begin
         st2_in.ns_q = -3'sd2;
         ns_off      = tdau_pkg::NS_PER_2SEC;
      end else if (in_data.ns_sum < 32'sd0) begin
         st2_in.ns_q = -3'sd1;
         ns_off      = tdau_pkg::NS_PER_SEC;
      end else if (in_data.ns_sum < tdau_pkg::NS_PER_SEC) begin
         st2_in.ns_q = 3'sd0;
         ns_off      = 32'sd0;
      end else if (in_data.ns_sum < tdau_pkg::NS_PER_2SEC) begin
         st2_in.ns_q = 3'sd1;
         ns_off      = -tdau_pkg::NS_PER_SEC;
      end else begin
         st2_in.ns_q = 3'sd2;
         ns_off      = -tdau_pkg::NS_PER_2SEC;
      end
      ns_r          = in_data.ns_sum + ns_off;
      st2_in.ns_r   = ns_r[29:0];
      st2_in.op     = in_data.op;
      st2_in.order  = in_data.order;
      st2_in.sec    = in_data.sec;
      st2_in.min    = in_data.min;
      st2_in.hour   = in_data.hour;
      st2_in.day    = in_data.day;
      day_x         = {{17{in_data.day[10]}}, in_data.day};
      hour_x        = {{19{in_data.hour[8]}}, in_data.hour};
      min_x         = {{19{in_data.min[8]}}, in_data.min};
      st2_in.p_day  = $signed(day_x) * tdau_pkg::SEC_PER_DAY;
      st2_in.p_hour = $signed(hour_x) * tdau_pkg::SEC_PER_HOUR;
      st2_in.p_min  = $signed(min_x) * tdau_pkg::MINUTE_SECS_W;
   end

   // stage 3
   always_comb begin
      sec_n = tdau_pkg::norm_small(st2_ff.sec + {{6{st2_ff.ns_q[2]}}, st2_ff.ns_q},
                                   tdau_pkg::MINUTE_SECS);
      min_n = tdau_pkg::norm_small(st2_ff.min + {{6{sec_n.q[2]}}, sec_n.q},
                                   tdau_pkg::MIN_PER_HOUR);
      st3_in.op    = st2_ff.op;
      st3_in.order = st2_ff.order;
      st3_in.ns_r  = st2_ff.ns_r;
      st3_in.sec_r = sec_n.r;
      st3_in.min_r = min_n.r;
      st3_in.hour  = st2_ff.hour + {{6{min_n.q[2]}}, min_n.q};
      st3_in.day   = st2_ff.day;
      st3_in.tot   = st2_ff.p_day + st2_ff.p_hour + st2_ff.p_min
                   + {{19{st2_ff.sec[8]}}, st2_ff.sec}
                   + {{25{st2_ff.ns_q[2]}}, st2_ff.ns_q};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy2) begin
            v2_ff <= in_valid;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         st2_ff <= st2_in;
      end
      if (rdy3) begin
         st3_ff <= st3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = st3_ff;

endmodule

@@ hdl/tdau_final.sv @@
// Last stage: hour and day carry, delta saturation, field selection by
// operation, and the result register. Depends on tdau_pkg.
module tdau_final (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tdau_pkg::s3_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tdau_pkg::rsp_type out_data
);

   tdau_pkg::rsp_type   rsp_ff, rsp_in;
   logic                v_ff;
   tdau_pkg::small_type hour_n;
   logic signed [27:0]  sat;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      hour_n = tdau_pkg::norm_small(in_data.hour, tdau_pkg::HOUR_PER_DAY);
      if (in_data.tot > tdau_pkg::DELTA_MAX) begin
         sat = tdau_pkg::DELTA_MAX;
      end else if (in_data.tot < tdau_pkg::DELTA_MIN) begin
         sat = tdau_pkg::DELTA_MIN;
      end else begin
         sat = in_data.tot;
      end
      rsp_in = '0;
      case (in_data.op) inside
         tdau_pkg::OP_ADD, tdau_pkg::OP_SUB: begin
            rsp_in.res_day    = in_data.day + {{8{hour_n.q[2]}}, hour_n.q};
            rsp_in.res_hour   = hour_n.r[4:0];
            rsp_in.res_minute = in_data.min_r;
            rsp_in.res_second = in_data.sec_r;
            rsp_in.res_nsec   = in_data.ns_r;
         end
         tdau_pkg::OP_COMPARE: begin
            rsp_in.order = in_data.order;
         end
         default: begin
            rsp_in.delta_sec  = sat[25:0];
            rsp_in.delta_nsec = in_data.ns_r;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = rsp_ff;

   a_time_normalized: assert property (@(posedge clock) disable iff (reset)
      v_ff |-> rsp_ff.res_hour < 5'd24 && rsp_ff.res_minute < 6'd60
               && rsp_ff.res_second < 6'd60 && rsp_ff.res_nsec < 30'd1000000000)
      else $error("result time fields not normalized");

   a_delta_rem: assert property (@(posedge clock) disable iff (reset)
      v_ff |-> rsp_ff.delta_nsec < 30'd1000000000)
      else $error("delta remainder out of range");

   a_order_alone: assert property (@(posedge clock) disable iff (reset)
      v_ff && rsp_ff.order != tdau_pkg::ORD_EQUAL |->
         rsp_ff.order != 2'b11 && rsp_ff.res_day == '0 && rsp_ff.res_nsec == '0
         && rsp_ff.delta_sec == '0 && rsp_ff.delta_nsec == '0)
      else $error("compare result mixed with other fields");

endmodule

@@ hdl/time_of_day_arithmetic_unit.sv @@
// Time-of-day add/subtract/compare/delta unit, top level.
// An accepted req is registered in tdau_prep, tdau_carry, then tdau_final.
// Throughput: one transaction per cycle; stalls ripple back stage by stage.
// Reset (synchronous, active high) clears the stage valid bits only.
// Depends on tdau_pkg, tdau_prep, tdau_carry, tdau_final.
module time_of_day_arithmetic_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_day, a_hour, a_minute, a_second, a_nsec, b_day, b_hour, b_minute,
   // b_second, b_nsec
   input  logic [111:0] req_tdata,
   // op, zero padding
   input  logic [7:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_day, res_hour, res_minute, res_second, res_nsec, order, delta_sec,
   // delta_nsec, zero padding
   output logic [119:0] rsp_tdata
);

   tdau_pkg::time_type a, b;
   tdau_pkg::s1_type   s1_data;
   tdau_pkg::s3_type   s3_data;
   tdau_pkg::rsp_type  rsp_data;
   logic               s1_valid, s1_ready, s3_valid, s3_ready;

   assign a.day    = req_tdata[8:0];
   assign a.hour   = req_tdata[13:9];
   assign a.minute = req_tdata[19:14];
   assign a.second = req_tdata[25:20];
   assign a.nsec   = req_tdata[55:26];
   assign b.day    = req_tdata[64:56];
   assign b.hour   = req_tdata[69:65];
   assign b.minute = req_tdata[75:70];
   assign b.second = req_tdata[81:76];
   assign b.nsec   = req_tdata[111:82];

   tdau_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser[1:0]),
      .in_a      (a),
      .in_b      (b),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   tdau_carry u_carry (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   tdau_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {4'b0000, rsp_data.delta_nsec, rsp_data.delta_sec, rsp_data.order,
                       rsp_data.res_nsec, rsp_data.res_second, rsp_data.res_minute,
                       rsp_data.res_hour, rsp_data.res_day};

endmodule
